@@ src/plp_pkg.sv @@
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types and constants for the line-permuting word-table loader.
// ----------------------------------------------------------------------------
package plp_pkg;

  // Field widths of the beats and registers
  localparam int IDX_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int OUT_ADDR_W = 12;
  localparam int VALUE_W    = 32;
  localparam int AMAP_W     = 40;
  localparam int DMAP_W     = 40;
  localparam int AXOR_W     = 10;
  localparam int DXOR_W     = 8;
  localparam int KEEP_W     = 32;
  localparam int SHIFT_W    = 5;
  localparam int DWID_W     = 4;
  localparam int BASE_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Address permutation geometry
  localparam int ADDR_LINES  = 10;
  localparam int AMAP_FIELDS = 10;
  localparam int AFIELD_W    = 4;
  localparam int DFIELD_W    = 5;
  localparam int DATA_BITS   = 8;
  localparam int DPERM_W     = 32;
  localparam int PERM_W      = 16;
  localparam int SUM_W       = PERM_W + 1;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_WORD_BITS   = 32;

  // Register reset values (identity maps, full byte width)
  localparam logic [AMAP_W-1:0] AMAP_RST = 40'h9876543210;
  localparam logic [DMAP_W-1:0] DMAP_RST = 40'd247132686368;
  localparam logic [DWID_W-1:0] DWID_RST = 4'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADDRESS_MAP = 3'd0,
    REG_DATA_MAP    = 3'd1,
    REG_ADDRESS_XOR = 3'd2,
    REG_DATA_XOR    = 3'd3,
    REG_KEEP_MASK   = 3'd4,
    REG_DATA_SHIFT  = 3'd5,
    REG_DATA_WIDTH  = 3'd6,
    REG_DEST_BASE   = 3'd7
  } cfg_reg_t;

  // Item opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  // Item sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIV,
    ST_REM,
    ST_READ,
    ST_MERGE
  } state_t;

  // Strobes for the modulo unit
  typedef struct packed {
    logic div_en;
    logic rem_en;
  } mod_ctl_t;

  // Strobes for the table memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

@@ src/plp_in_if.sv @@
// ----------------------------------------------------------------------------
// plp_in_if
// Input channel: one load or read item per beat.
// ----------------------------------------------------------------------------
interface plp_in_if;
  import plp_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [IDX_W-1:0]  index;
  logic [BYTE_W-1:0] source_byte;

  modport source (output valid, opcode, index, source_byte, input ready);
  modport sink   (input valid, opcode, index, source_byte, output ready);

endinterface

@@ src/plp_out_if.sv @@
// ----------------------------------------------------------------------------
// plp_out_if
// Result channel: one table address and word per beat.
// ----------------------------------------------------------------------------
interface plp_out_if;
  import plp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] word_address;
  logic [VALUE_W-1:0]    word_value;

  modport source (output valid, word_address, word_value, input ready);
  modport sink   (input valid, word_address, word_value, output ready);

endinterface

@@ src/prom_line_permute_loader.sv @@
// ----------------------------------------------------------------------------
// prom_line_permute_loader
// Builds a word table from source ROM bytes through address line and data
// bit permutation, and reads stored words back.
// ----------------------------------------------------------------------------
// One item is taken at a time and goes from acceptance to its result in the
// output register through address and data permutation, two steps of
// modulo reduction by the table depth, the memory read and the merge with
// write-back; input ready returns the cycle after, so no new item is accepted
// until the last one is written back. The table is a single memory with one
// write and one read port and a registered read; input ready stays low after
// reset while a clearing pass zeroes it. A result waits in the output
// register while the next item is accepted and worked on; that item holds at
// write-back until the waiting result is taken. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while no item is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module prom_line_permute_loader #(
  parameter int TABLE_DEPTH = plp_pkg::DEF_TABLE_DEPTH,
  parameter int WORD_BITS   = plp_pkg::DEF_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  plp_in_if.sink                            in_ch,
  plp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [plp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import plp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // Configuration registers
  logic [AMAP_W-1:0]  address_map_r;
  logic [DMAP_W-1:0]  data_map_r;
  logic [AXOR_W-1:0]  address_xor_r;
  logic [DXOR_W-1:0]  data_xor_r;
  logic [KEEP_W-1:0]  keep_mask_r;
  logic [SHIFT_W-1:0] data_shift_r;
  logic [DWID_W-1:0]  data_width_r;
  logic [BASE_W-1:0]  dest_base_r;

  // Sequencer and item registers
  state_t               state_r;
  state_t               state_nxt;
  opcode_t              op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [SUM_W-1:0]     sum_r;
  logic [WORD_BITS-1:0] data_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_ADDR_W-1:0] out_addr_r;
  logic [VALUE_W-1:0]    out_value_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 slot_free;
  logic                 clr_busy;
  logic                 is_load;
  logic [SUM_W-1:0]     sum;
  logic [WORD_BITS-1:0] data;
  logic [AW-1:0]        addr;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] mrg_word;
  logic [WORD_BITS-1:0] res_word;
  mod_ctl_t             mod_ctl;
  tbl_ctl_t             tbl_ctl;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_map_r <= AMAP_RST;
      data_map_r    <= DMAP_RST;
      address_xor_r <= '0;
      data_xor_r    <= '0;
      keep_mask_r   <= '0;
      data_shift_r  <= '0;
      data_width_r  <= DWID_RST;
      dest_base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ADDRESS_MAP: address_map_r <= AMAP_W'(cfg_wdata);
        REG_DATA_MAP:    data_map_r    <= DMAP_W'(cfg_wdata);
        REG_ADDRESS_XOR: address_xor_r <= AXOR_W'(cfg_wdata);
        REG_DATA_XOR:    data_xor_r    <= DXOR_W'(cfg_wdata);
        REG_KEEP_MASK:   keep_mask_r   <= KEEP_W'(cfg_wdata);
        REG_DATA_SHIFT:  data_shift_r  <= SHIFT_W'(cfg_wdata);
        REG_DATA_WIDTH:  data_width_r  <= DWID_W'(cfg_wdata);
        REG_DEST_BASE:   dest_base_r   <= BASE_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_ch.ready = (state_r == ST_IDLE) && !clr_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign is_load     = (op_r == OP_LOAD);

  // Next state and strobes
  always_comb begin
    state_nxt      = state_r;
    mod_ctl.div_en = 1'b0;
    mod_ctl.rem_en = 1'b0;
    tbl_ctl.rd_en  = 1'b0;
    tbl_ctl.wr_en  = 1'b0;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        mod_ctl.div_en = 1'b1;
        state_nxt      = ST_REM;
      end
      ST_REM: begin
        mod_ctl.rem_en = 1'b1;
        state_nxt      = ST_READ;
      end
      ST_READ: begin
        tbl_ctl.rd_en = 1'b1;
        state_nxt     = ST_MERGE;
      end
      ST_MERGE: begin
        if (slot_free) begin
          tbl_ctl.wr_en = is_load;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= opcode_t'(in_ch.opcode);
      idx_r  <= in_ch.index;
      byte_r <= in_ch.source_byte;
    end
  end

  plp_map #(
    .WORD_BITS (WORD_BITS)
  ) u_map (
    .is_load     (is_load),
    .index       (idx_r),
    .source_byte (byte_r),
    .address_map (address_map_r),
    .data_map    (data_map_r),
    .address_xor (address_xor_r),
    .data_xor    (data_xor_r),
    .data_shift  (data_shift_r),
    .data_width  (data_width_r),
    .dest_base   (dest_base_r),
    .sum         (sum),
    .data        (data)
  );

  // Hold the permuted sum and data for the rest of the item
  always_ff @(posedge clk) begin
    if (state_r == ST_MAP) begin
      sum_r  <= sum;
      data_r <= data;
    end
  end

  plp_mod #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk  (clk),
    .ctl  (mod_ctl),
    .sum  (sum_r),
    .addr (addr)
  );

  plp_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .addr     (addr),
    .data     (data_r),
    .keep     (WORD_BITS'(keep_mask_r)),
    .rd_word  (rd_word),
    .mrg_word (mrg_word),
    .clr_busy (clr_busy)
  );

  // Load the result register at write-back
  assign res_word = is_load ? mrg_word : rd_word;

  always_ff @(posedge clk) begin
    if ((state_r == ST_MERGE) && slot_free) begin
      out_addr_r  <= OUT_ADDR_W'({{OUT_ADDR_W{1'b0}}, addr});
      out_value_r <= VALUE_W'(res_word);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.word_address = out_addr_r;
  assign out_ch.word_value   = out_value_r;

endmodule

@@ src/plp_map.sv @@
// ----------------------------------------------------------------------------
// plp_map
// Address line and data bit permutation; forms the unreduced table address
// and the shifted data word of one item.
// ----------------------------------------------------------------------------
module plp_map #(
  parameter int WORD_BITS = plp_pkg::DEF_WORD_BITS
) (
  input  logic                          is_load,
  input  logic [plp_pkg::IDX_W-1:0]     index,
  input  logic [plp_pkg::BYTE_W-1:0]    source_byte,
  input  logic [plp_pkg::AMAP_W-1:0]    address_map,
  input  logic [plp_pkg::DMAP_W-1:0]    data_map,
  input  logic [plp_pkg::AXOR_W-1:0]    address_xor,
  input  logic [plp_pkg::DXOR_W-1:0]    data_xor,
  input  logic [plp_pkg::SHIFT_W-1:0]   data_shift,
  input  logic [plp_pkg::DWID_W-1:0]    data_width,
  input  logic [plp_pkg::BASE_W-1:0]    dest_base,
  output logic [plp_pkg::SUM_W-1:0]     sum,
  output logic [WORD_BITS-1:0]          data
);
  import plp_pkg::*;

  logic [ADDR_LINES-1:0] logical;
  logic [PERM_W-1:0]     aperm;
  logic [DWID_W-1:0]     wid;
  logic [BYTE_W-1:0]     dbyte;
  logic [DPERM_W-1:0]    dperm;
  logic [DPERM_W-1:0]    dshift;

  // Route each logical address line to its destination line
  always_comb begin
    logical = ADDR_LINES'(index ^ IDX_W'(address_xor));
    aperm   = '0;
    for (int i = 0; i < ADDR_LINES; i++) begin
      if (logical[i]) begin
        if (i < AMAP_FIELDS) begin
          aperm[address_map[AFIELD_W*i +: AFIELD_W]] = 1'b1;
        end else begin
          aperm[i] = 1'b1;
        end
      end
    end
  end

  // Add the page base for loads; reads take the index as it is
  assign sum = is_load ? (SUM_W'(aperm) + SUM_W'(dest_base)) : SUM_W'(index);

  // Apply the data XOR, keep the low data bits, scatter them and shift into word position
  always_comb begin
    wid   = (data_width > DWID_W'(DATA_BITS)) ? DWID_W'(DATA_BITS) : data_width;
    dbyte = source_byte ^ data_xor;
    dperm = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if ((DWID_W'(i) < wid) && dbyte[i]) begin
        dperm[data_map[DFIELD_W*i +: DFIELD_W]] = 1'b1;
      end
    end
    dshift = dperm << data_shift;
  end

  assign data = WORD_BITS'(dshift);

endmodule

@@ src/plp_mod.sv @@
// ----------------------------------------------------------------------------
// plp_mod
// Two-step reduction of an address sum modulo the table depth: reciprocal
// multiply for the quotient, then multiply back and subtract.
// ----------------------------------------------------------------------------
module plp_mod #(
  parameter int TABLE_DEPTH = plp_pkg::DEF_TABLE_DEPTH
) (
  input  logic                               clk,
  input  plp_pkg::mod_ctl_t                  ctl,
  input  logic [plp_pkg::SUM_W-1:0]          sum,
  output logic [$clog2(TABLE_DEPTH)-1:0]     addr
);
  import plp_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int SHIFT_K = SUM_W + AW;
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT_K) + TABLE_DEPTH - 1) / TABLE_DEPTH;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q_r;
  logic [SUM_W-1:0]  q_nxt;
  logic [SUM_W-1:0]  qd;
  logic [SUM_W-1:0]  rem;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     addr_nxt;

  // Quotient: exact for every sum of SUM_W bits
  assign prod  = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
  assign q_nxt = SUM_W'(prod >> SHIFT_K);

  // Remainder: result lies below the depth, so SUM_W-bit wrap is exact
  assign qd       = q_r * SUM_W'(TABLE_DEPTH);
  assign rem      = sum - qd;
  assign addr_nxt = AW'(rem);

  // Hold each step until its strobe
  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      q_r <= q_nxt;
    end
    if (ctl.rem_en) begin
      addr_r <= addr_nxt;
    end
  end

  assign addr = addr_r;

endmodule

@@ src/plp_table.sv @@
// ----------------------------------------------------------------------------
// plp_table
// Word table memory with the post-reset clearing pass and the
// read-modify-write merge of a load.
// ----------------------------------------------------------------------------
module plp_table #(
  parameter int TABLE_DEPTH = plp_pkg::DEF_TABLE_DEPTH,
  parameter int WORD_BITS   = plp_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plp_pkg::tbl_ctl_t               ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0]  addr,
  input  logic [WORD_BITS-1:0]            data,
  input  logic [WORD_BITS-1:0]            keep,
  output logic [WORD_BITS-1:0]            rd_word,
  output logic [WORD_BITS-1:0]            mrg_word,
  output logic                            clr_busy
);
  import plp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [WORD_BITS-1:0] mem [TABLE_DEPTH];
  logic [WORD_BITS-1:0] rd_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        clr_cnt_nxt;
  logic                 clr_busy_r;
  logic                 clr_busy_nxt;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  // Advance the clearing pass one entry per cycle after reset
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // Merge old word with the load data
  assign mrg_word = (rd_r & keep) ^ data;

  // Write port: clearing pass or load write-back
  assign we = clr_busy_r || ctl.wr_en;
  assign wa = clr_busy_r ? clr_cnt_r : addr;
  assign wd = clr_busy_r ? '0 : mrg_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign rd_word  = rd_r;
  assign clr_busy = clr_busy_r;

endmodule
